[rtl/bpa_pkg.sv]
// Package with the sizes, field widths and operation codes of the bitmap page allocator.
package bpa_pkg;

    localparam int NUM_PAGES   = 8192;
    localparam int PAGE_BYTES  = 4096;
    localparam int WORD_BITS   = 32;
    localparam int MAP_WORDS   = NUM_PAGES / WORD_BITS;

    localparam int PAGE_SHIFT  = $clog2(PAGE_BYTES);
    localparam int PAGE_W      = $clog2(NUM_PAGES);
    localparam int BIT_W       = $clog2(WORD_BITS);
    localparam int WORD_W      = $clog2(MAP_WORDS);

    localparam int OP_W        = 2;
    localparam int IN_ADDR_W   = 32;
    localparam int ADDR_W      = 25;
    localparam int COUNT_W     = 14;

    localparam logic [COUNT_W-1:0] RESERVED_RESET = 14'd513;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC  = 2'd0,
        OP_FREE   = 2'd1,
        OP_REINIT = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

endpackage

[rtl/bitmap_page_allocator.sv]
// First-fit bitmap page allocator with a one-bit-per-page used map in a 256 x 32 memory.
// Alloc: the map is scanned one word per cycle, from word 0 up to the first word with a free bit.
// Free: read, modify-write, result; an out-of-range free and the unused code go straight to the result.
// Reinit: the map is rewritten one word per cycle, then the result is given.
// One transaction is in work at a time; in_stall is high until its result is registered.
// After rst_n the map is rebuilt with 513 reserved pages; no input meanwhile.
module bitmap_page_allocator (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [bpa_pkg::OP_W-1:0]        operation,
    input  logic [bpa_pkg::IN_ADDR_W-1:0]   free_address,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [bpa_pkg::ADDR_W-1:0]      page_address,
    output logic                            out_of_memory,
    output logic                            page_released,
    output logic [bpa_pkg::COUNT_W-1:0]     free_count,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bpa_pkg::COUNT_W-1:0]     cfg_data
);
    import bpa_pkg::*;

    typedef enum logic [2:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_SCAN,
        ST_FREE_CHK,
        ST_RESP
    } state_t;

    typedef logic [WORD_BITS-1:0] word_t;

    word_t                  mem [MAP_WORDS];
    word_t                  rdata_reg;

    state_t                 state_reg, state_next;
    logic [COUNT_W-1:0]     reserved_reg, reserved_next;
    logic [COUNT_W-1:0]     sweep_n_reg, sweep_n_next;
    logic                   sweep_reply_reg, sweep_reply_next;
    logic [WORD_W-1:0]      scan_addr_reg, scan_addr_next;
    logic [WORD_W-1:0]      chk_addr_reg, chk_addr_next;
    logic                   chk_valid_reg, chk_valid_next;
    logic [BIT_W-1:0]       bit_reg, bit_next;
    logic [COUNT_W-1:0]     free_total_reg, free_total_next;
    logic [ADDR_W-1:0]      res_addr_reg, res_addr_next;
    logic                   res_oom_reg, res_oom_next;
    logic                   res_rel_reg, res_rel_next;
    logic                   out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0]      out_addr_reg, out_addr_next;
    logic                   out_oom_reg, out_oom_next;
    logic                   out_rel_reg, out_rel_next;
    logic [COUNT_W-1:0]     out_count_reg, out_count_next;

    logic                   mem_we;
    logic [WORD_W-1:0]      mem_waddr;
    word_t                  mem_wdata;
    logic [WORD_W-1:0]      mem_raddr;

    logic                   in_accept;
    logic [COUNT_W-1:0]     cfg_clamped;
    logic [WORD_W:0]        full_words;
    logic [WORD_W:0]        sweep_word;
    word_t                  sweep_value;
    logic                   word_has_free;
    logic [BIT_W-1:0]       first_free;
    logic [PAGE_W-1:0]      alloc_page;
    logic [IN_ADDR_W-PAGE_SHIFT-1:0] free_page;
    logic                   free_in_range;

    assign in_stall      = (state_reg != ST_IDLE);
    assign in_accept     = in_valid && !in_stall;
    assign cfg_ready     = 1'b1;
    assign out_valid     = out_valid_reg;
    assign page_address  = out_addr_reg;
    assign out_of_memory = out_oom_reg;
    assign page_released = out_rel_reg;
    assign free_count    = out_count_reg;

    assign cfg_clamped = (reserved_reg > COUNT_W'(NUM_PAGES)) ? COUNT_W'(NUM_PAGES)
                                                              : reserved_reg;
    assign full_words  = sweep_n_reg[COUNT_W-1:BIT_W];
    assign sweep_word  = {1'b0, scan_addr_reg};

    always_comb
    begin
        if (sweep_word < full_words)
        begin
            sweep_value = '1;
        end
        else if (sweep_word == full_words)
        begin
            sweep_value = (word_t'(1) << sweep_n_reg[BIT_W-1:0]) - word_t'(1);
        end
        else
        begin
            sweep_value = '0;
        end
    end

    always_comb
    begin
        first_free = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (!rdata_reg[i])
            begin
                first_free = BIT_W'(i);
            end
        end
    end

    assign word_has_free = (rdata_reg != '1);
    assign alloc_page    = {chk_addr_reg, first_free};
    assign free_page     = free_address[IN_ADDR_W-1:PAGE_SHIFT];
    assign free_in_range = (free_page[IN_ADDR_W-PAGE_SHIFT-1:PAGE_W] == '0);

    always_comb
    begin
        state_next       = state_reg;
        reserved_next    = reserved_reg;
        sweep_n_next     = sweep_n_reg;
        sweep_reply_next = sweep_reply_reg;
        scan_addr_next   = scan_addr_reg;
        chk_addr_next    = chk_addr_reg;
        chk_valid_next   = chk_valid_reg;
        bit_next         = bit_reg;
        free_total_next  = free_total_reg;
        res_addr_next    = res_addr_reg;
        res_oom_next     = res_oom_reg;
        res_rel_next     = res_rel_reg;
        out_valid_next   = out_valid_reg;
        out_addr_next    = out_addr_reg;
        out_oom_next     = out_oom_reg;
        out_rel_next     = out_rel_reg;
        out_count_next   = out_count_reg;
        mem_we           = 1'b0;
        mem_waddr        = scan_addr_reg;
        mem_wdata        = sweep_value;
        mem_raddr        = scan_addr_reg;

        if (cfg_valid && cfg_ready)
        begin
            reserved_next = cfg_data;
        end

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_SWEEP:
            begin
                mem_we = 1'b1;
                scan_addr_next = scan_addr_reg + WORD_W'(1);
                if (scan_addr_reg == WORD_W'(MAP_WORDS - 1))
                begin
                    free_total_next = COUNT_W'(NUM_PAGES) - sweep_n_reg;
                    state_next = sweep_reply_reg ? ST_RESP : ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    res_addr_next = '0;
                    res_oom_next  = 1'b0;
                    res_rel_next  = 1'b0;
                    case (op_t'(operation))
                        OP_ALLOC:
                        begin
                            mem_raddr      = '0;
                            chk_addr_next  = '0;
                            chk_valid_next = 1'b1;
                            scan_addr_next = WORD_W'(1);
                            state_next     = ST_SCAN;
                        end
                        OP_FREE:
                        begin
                            mem_raddr     = free_page[PAGE_W-1:BIT_W];
                            chk_addr_next = free_page[PAGE_W-1:BIT_W];
                            bit_next      = free_page[BIT_W-1:0];
                            state_next    = free_in_range ? ST_FREE_CHK : ST_RESP;
                        end
                        OP_REINIT:
                        begin
                            sweep_n_next     = cfg_clamped;
                            sweep_reply_next = 1'b1;
                            scan_addr_next   = '0;
                            state_next       = ST_SWEEP;
                        end
                        default:
                        begin
                            state_next = ST_RESP;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (chk_valid_reg && word_has_free)
                begin
                    mem_we          = 1'b1;
                    mem_waddr       = chk_addr_reg;
                    mem_wdata       = rdata_reg | (word_t'(1) << first_free);
                    free_total_next = free_total_reg - COUNT_W'(1);
                    res_addr_next   = {alloc_page, PAGE_SHIFT'(0)};
                    state_next      = ST_RESP;
                end
                else if (chk_valid_reg && chk_addr_reg == WORD_W'(MAP_WORDS - 1))
                begin
                    res_oom_next = 1'b1;
                    state_next   = ST_RESP;
                end
                else
                begin
                    chk_addr_next  = scan_addr_reg;
                    chk_valid_next = 1'b1;
                    scan_addr_next = scan_addr_reg + WORD_W'(1);
                end
            end
            ST_FREE_CHK:
            begin
                if (rdata_reg[bit_reg])
                begin
                    mem_we          = 1'b1;
                    mem_waddr       = chk_addr_reg;
                    mem_wdata       = rdata_reg & ~(word_t'(1) << bit_reg);
                    free_total_next = free_total_reg + COUNT_W'(1);
                    res_rel_next    = 1'b1;
                end
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_addr_next  = res_addr_reg;
                    out_oom_next   = res_oom_reg;
                    out_rel_next   = res_rel_reg;
                    out_count_next = free_total_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_SWEEP;
            reserved_reg    <= RESERVED_RESET;
            sweep_n_reg     <= RESERVED_RESET;
            sweep_reply_reg <= 1'b0;
            scan_addr_reg   <= '0;
            chk_valid_reg   <= 1'b0;
            free_total_reg  <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            reserved_reg    <= reserved_next;
            sweep_n_reg     <= sweep_n_next;
            sweep_reply_reg <= sweep_reply_next;
            scan_addr_reg   <= scan_addr_next;
            chk_valid_reg   <= chk_valid_next;
            free_total_reg  <= free_total_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chk_addr_reg  <= chk_addr_next;
        bit_reg       <= bit_next;
        res_addr_reg  <= res_addr_next;
        res_oom_reg   <= res_oom_next;
        res_rel_reg   <= res_rel_next;
        out_addr_reg  <= out_addr_next;
        out_oom_reg   <= out_oom_next;
        out_rel_reg   <= out_rel_next;
        out_count_reg <= out_count_next;
    end

endmodule

[dv/bpa_checker.sv]
// Scoreboard for the bitmap page allocator: tracks the page map, predicts each result and compares.
`timescale 1ns / 1ps

module bpa_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_stall,
    input  logic [bpa_pkg::OP_W-1:0]        operation,
    input  logic [bpa_pkg::IN_ADDR_W-1:0]   free_address,
    input  logic                            out_valid,
    input  logic                            out_stall,
    input  logic [bpa_pkg::ADDR_W-1:0]      page_address,
    input  logic                            out_of_memory,
    input  logic                            page_released,
    input  logic [bpa_pkg::COUNT_W-1:0]     free_count,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [bpa_pkg::COUNT_W-1:0]     cfg_data,
    output int                              failures,
    output int                              pending
);
    import bpa_pkg::*;

    typedef struct packed {
        logic [ADDR_W-1:0]  page_address;
        logic               out_of_memory;
        logic               page_released;
        logic [COUNT_W-1:0] free_count;
    } page_result_t;

    localparam logic [NUM_PAGES-1:0] ALL_PAGES = '1;

    logic [NUM_PAGES-1:0]   page_in_use;
    logic [COUNT_W-1:0]     pages_free;
    logic [COUNT_W-1:0]     reserve_setting;
    page_result_t           awaited_results[$];
    page_result_t           want_result;
    int                     mismatches;

    function automatic void rebuild_page_map();
        int unsigned held;
        held = (reserve_setting > NUM_PAGES) ? NUM_PAGES : reserve_setting;
        page_in_use = ~(ALL_PAGES << held);
        pages_free = COUNT_W'(NUM_PAGES - held);
    endfunction

    function automatic page_result_t apply_page_op(op_t op, logic [IN_ADDR_W-1:0] addr);
        page_result_t res;
        logic [IN_ADDR_W-1:0] page;
        res = '0;
        case (op)
            OP_ALLOC:
            begin
                res.out_of_memory = 1'b1;
                for (int p = 0; p < NUM_PAGES; p++)
                begin
                    if (!page_in_use[p])
                    begin
                        page_in_use[p] = 1'b1;
                        pages_free = pages_free - 1'b1;
                        res.page_address = ADDR_W'(p * PAGE_BYTES);
                        res.out_of_memory = 1'b0;
                        break;
                    end
                end
            end
            OP_FREE:
            begin
                page = addr / PAGE_BYTES;
                if (page < NUM_PAGES)
                begin
                    if (page_in_use[page[PAGE_W-1:0]])
                    begin
                        page_in_use[page[PAGE_W-1:0]] = 1'b0;
                        pages_free = pages_free + 1'b1;
                        res.page_released = 1'b1;
                    end
                end
            end
            OP_REINIT:
            begin
                rebuild_page_map();
            end
            default:
            begin
            end
        endcase
        res.free_count = pages_free;
        return res;
    endfunction

    function automatic int field_differs(string field, longint unsigned want,
                                         longint unsigned got);
        if (want == got)
            return 0;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        return 1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reserve_setting = RESERVED_RESET;
            rebuild_page_map();
            awaited_results.delete();
            mismatches = 0;
            failures <= 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                reserve_setting = cfg_data;
            if (in_valid && !in_stall)
                awaited_results.push_back(apply_page_op(op_t'(operation), free_address));
            if (out_valid && !out_stall)
            begin
                if (awaited_results.size() == 0)
                begin
                    $display("%0t: result with none expected, actual addr %0d oom %0d rel %0d count %0d",
                             $time, page_address, out_of_memory, page_released, free_count);
                    mismatches++;
                end
                else
                begin
                    want_result = awaited_results.pop_front();
                    mismatches += field_differs("page_address", want_result.page_address,
                                                page_address);
                    mismatches += field_differs("out_of_memory", want_result.out_of_memory,
                                                out_of_memory);
                    mismatches += field_differs("page_released", want_result.page_released,
                                                page_released);
                    mismatches += field_differs("free_count", want_result.free_count,
                                                free_count);
                end
            end
            failures <= mismatches;
            pending <= awaited_results.size();
        end
    end

endmodule

[dv/tb_bitmap_page_allocator.sv]
// Top of the bitmap page allocator testbench: clock, reset, stimulus, result pacing and verdict.
`timescale 1ns / 1ps

module tb_bitmap_page_allocator;
    import bpa_pkg::*;

    localparam int ITEM_TARGET  = 1750;
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int DRAIN_CYCLES = 260;
    localparam int MAX_IDLE     = 17;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [OP_W-1:0]      operation = '0;
    logic [IN_ADDR_W-1:0] free_address = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [ADDR_W-1:0]    page_address;
    logic                 out_of_memory;
    logic                 page_released;
    logic [COUNT_W-1:0]   free_count;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [COUNT_W-1:0]   cfg_data = '0;

    int                   failures;
    int                   pending;
    int                   cycle_count = 0;
    int                   items_sent = 0;
    int unsigned          map_floor = RESERVED_RESET;
    int unsigned          grants = 0;
    logic [COUNT_W-1:0]   last_reserve = RESERVED_RESET;
    bit                   quiet = 1'b0;
    int unsigned          rx_hold = 0;
    int unsigned          rx_draw;

    always #5 clk = ~clk;

    bitmap_page_allocator dut (
        .clk,
        .rst_n,
        .in_valid,
        .in_stall,
        .operation,
        .free_address,
        .out_valid,
        .out_stall,
        .page_address,
        .out_of_memory,
        .page_released,
        .free_count,
        .cfg_valid,
        .cfg_ready,
        .cfg_data
    );

    bpa_checker u_checker (
        .clk,
        .rst_n,
        .in_valid,
        .in_stall,
        .operation,
        .free_address,
        .out_valid,
        .out_stall,
        .page_address,
        .out_of_memory,
        .page_released,
        .free_count,
        .cfg_valid,
        .cfg_ready,
        .cfg_data,
        .failures,
        .pending
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb_bitmap_page_allocator failed");
            $finish;
        end
    end

    // after each accepted result, hold the next one for a drawn number of cycles once it shows up
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            rx_hold <= 0;
        end
        else if (out_valid && !out_stall)
        begin
            rx_draw = quiet ? 0 : $urandom_range(0, MAX_IDLE);
            rx_hold <= rx_draw;
            out_stall <= (rx_draw != 0);
        end
        else if (rx_hold != 0 && out_valid)
        begin
            rx_hold <= rx_hold - 1;
            out_stall <= (rx_hold != 1);
        end
    end

    task automatic send_op(op_t op, logic [IN_ADDR_W-1:0] addr);
        int unsigned gap;
        gap = quiet ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        operation <= op;
        free_address <= addr;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
        if (op == OP_ALLOC)
            grants++;
        else if (op == OP_REINIT)
        begin
            map_floor = (last_reserve > NUM_PAGES) ? NUM_PAGES : last_reserve;
            grants = 0;
        end
    endtask

    task automatic set_reserve(logic [COUNT_W-1:0] value);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        last_reserve = value;
    endtask

    initial
    begin : stimulus
        logic [COUNT_W-1:0] next_reserve;
        int unsigned        burst;
        int unsigned        pick;
        int unsigned        top_page;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        send_op(OP_ALLOC, $urandom);
        send_op(OP_FREE, RESERVED_RESET * PAGE_BYTES + PAGE_BYTES - 1);
        send_op(OP_FREE, RESERVED_RESET * PAGE_BYTES);
        send_op(OP_FREE, 32'hFFFF_FFFF);
        send_op(OP_FREE, NUM_PAGES * PAGE_BYTES);
        send_op(OP_FREE, (NUM_PAGES - 1) * PAGE_BYTES);
        send_op(OP_NONE, $urandom);
        send_op(OP_FREE, 0);
        send_op(OP_ALLOC, 0);
        send_op(OP_ALLOC, $urandom);

        set_reserve('1);
        send_op(OP_REINIT, $urandom);
        send_op(OP_ALLOC, $urandom);
        send_op(OP_FREE, (NUM_PAGES - 1) * PAGE_BYTES + 12'hABC);
        send_op(OP_ALLOC, $urandom);
        send_op(OP_ALLOC, $urandom);

        set_reserve('0);
        send_op(OP_ALLOC, $urandom);
        send_op(OP_REINIT, $urandom);
        send_op(OP_ALLOC, $urandom);
        send_op(OP_FREE, 0);
        send_op(OP_FREE, 0);

        while (items_sent < ITEM_TARGET)
        begin
            quiet = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 7))
                0: next_reserve = '0;
                1: next_reserve = COUNT_W'(NUM_PAGES);
                2: next_reserve = '1;
                3: next_reserve = COUNT_W'(NUM_PAGES - $urandom_range(1, 40));
                4: next_reserve = COUNT_W'($urandom);
                5: next_reserve = RESERVED_RESET;
                6: next_reserve = COUNT_W'(NUM_PAGES - $urandom_range(0, 200));
                default: next_reserve = COUNT_W'($urandom_range(0, 600));
            endcase
            set_reserve(next_reserve);
            if ($urandom_range(0, 4) != 0)
                send_op(OP_REINIT, $urandom);
            burst = $urandom_range(40, 120);
            repeat (burst)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 45)
                    send_op(OP_ALLOC, $urandom);
                else if (pick < 85)
                begin
                    top_page = map_floor + grants + 4;
                    if (top_page > NUM_PAGES - 1)
                        top_page = NUM_PAGES - 1;
                    send_op(OP_FREE, $urandom_range(0, top_page) * PAGE_BYTES
                                     + $urandom_range(0, PAGE_BYTES - 1));
                end
                else if (pick < 90)
                    send_op(OP_FREE, $urandom);
                else if (pick < 94)
                    send_op(OP_REINIT, $urandom);
                else if (pick < 97)
                    send_op(OP_NONE, $urandom);
                else
                    send_op(OP_FREE, $urandom_range(NUM_PAGES * PAGE_BYTES, 32'hFFFF_FFFF));
            end
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failures == 0)
            $display("tb_bitmap_page_allocator passed");
        else
            $display("tb_bitmap_page_allocator failed");
        $finish;
    end

endmodule

[files.f]
rtl/bpa_pkg.sv
rtl/bitmap_page_allocator.sv
dv/bpa_checker.sv
dv/tb_bitmap_page_allocator.sv
